>>> src/pdld_pkg.sv
// ---------------------------------------------------------------------------
// pdld_pkg
// Types and codes shared by the prefill/decode load dispatcher modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pdld_pkg;

   // item op codes
   localparam logic [2:0] OP_PF_ASSIGN  = 3'd0;
   localparam logic [2:0] OP_DC_ASSIGN  = 3'd1;
   localparam logic [2:0] OP_PF_RELEASE = 3'd2;
   localparam logic [2:0] OP_DC_RELEASE = 3'd3;
   localparam logic [2:0] OP_TOKEN_ADJ  = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_QFULL     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_PF_COUNT  = 3'd0;
   localparam logic [2:0] CSR_DC_COUNT  = 3'd1;
   localparam logic [2:0] CSR_PF_CAP    = 3'd2;
   localparam logic [2:0] CSR_DC_CAP    = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD = 3'd4;
   localparam logic [2:0] CSR_PREDICT   = 3'd5;

   localparam int BYTES_PER_TOKEN_SHIFT = 2;
   localparam int SIM_LOAD_W            = 43;
   localparam int SIM_REQ_W             = 17;

   typedef struct packed {
      logic [2:0]         op;
      logic [3:0]         peer;
      logic [23:0]        byte_len;
      logic [15:0]        tag;
      logic [31:0]        now_ms;
      logic signed [31:0] token_delta;
   } req_type;

   typedef struct packed {
      logic [3:0] chosen_peer;
      logic [1:0] status;
      logic [6:0] queued_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pact;
      logic [39:0] pload;
      logic [15:0] dact;
      logic [39:0] dtok;
   } peer_entry_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [23:0] length;
      logic [31:0] time_ms;
   } queue_entry_type;

   typedef struct packed {
      logic [SIM_LOAD_W-1:0] load;
      logic [SIM_REQ_W-1:0]  req;
   } sim_entry_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [23:0]        length;
      logic signed [31:0] delta;
   } upd_cmd_type;

endpackage

`default_nettype wire

>>> src/pdld_ram.sv
// ---------------------------------------------------------------------------
// pdld_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pdld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/pdld_peer_upd.sv
// ---------------------------------------------------------------------------
// pdld_peer_upd
// Counter update for one peer entry: saturating increments, floored
// decrements and signed token adjustment.
// ---------------------------------------------------------------------------
`default_nettype none

module pdld_peer_upd
   import pdld_pkg::*;
(
   input  wire upd_cmd_type    cmd,
   input  wire peer_entry_type cur,
   output peer_entry_type      nxt
);

   function automatic logic [15:0] inc_sat(input logic [15:0] a);
      return (a == 16'hFFFF) ? a : a + 16'd1;
   endfunction

   function automatic logic [15:0] dec_floor(input logic [15:0] a);
      return (a == 16'd0) ? a : a - 16'd1;
   endfunction

   function automatic logic [39:0] add_sat(input logic [39:0] a, input logic [39:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
   endfunction

   function automatic logic [39:0] sub_floor(input logic [39:0] a, input logic [39:0] b);
      return (b > a) ? 40'd0 : a - b;
   endfunction

   logic signed [33:0] dx;
   logic [32:0]        mag;
   logic [39:0]        tok_adj;

   assign dx      = (cmd.op == OP_DC_RELEASE) ? -34'(cmd.delta) : 34'(cmd.delta);
   assign mag     = dx[33] ? 33'(-dx) : 33'(dx);
   assign tok_adj = dx[33] ? sub_floor(cur.dtok, 40'(mag)) : add_sat(cur.dtok, 40'(mag));

   always_comb begin
      nxt = cur;
      case (cmd.op)
         OP_PF_ASSIGN: begin
            nxt.pact  = inc_sat(cur.pact);
            nxt.pload = add_sat(cur.pload, 40'(cmd.length));
         end
         OP_DC_ASSIGN: begin
            nxt.dact = inc_sat(cur.dact);
            nxt.dtok = add_sat(cur.dtok, 40'(cmd.length >> BYTES_PER_TOKEN_SHIFT));
         end
         OP_PF_RELEASE: begin
            nxt.pact  = dec_floor(cur.pact);
            nxt.pload = sub_floor(cur.pload, 40'(cmd.length));
         end
         OP_DC_RELEASE: begin
            nxt.dact = dec_floor(cur.dact);
            nxt.dtok = tok_adj;
         end
         OP_TOKEN_ADJ: begin
            nxt.dtok = tok_adj;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/prefill_decode_load_dispatcher.sv
// ---------------------------------------------------------------------------
// prefill_decode_load_dispatcher
// Picks prefill and decode peers for request items, keeps per-peer counters
// and a time-ordered queue of running prefill requests.
// ---------------------------------------------------------------------------
// Usage:
//  req_* carries one event item; it is taken when req_valid is high and
//  req_stall is low. One result item per event leaves on rsp_*, held while
//  rsp_stall is high. The user must let csr_* write a register only while
//  the block is idle; the block does not enforce it. Items are handled one
//  at a time, in these steps:
//   prefill assign : peer scan, time-ordered queue insert, peer update
//   decode assign  : peer scan, optional load simulation, peer update
//   prefill release: queue tag search, queue shift, peer update
//   others         : peer update
//  The peer table, queue and simulation scratch live in RAMs with one read
//  and one write port, so each scan walks one entry per cycle.
//  After reset all peer counters read zero (per-entry valid bits), the queue
//  is empty and no clearing pass is needed. A stalled result waits in the
//  output register; the next event is accepted meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module prefill_decode_load_dispatcher
   import pdld_pkg::*;
#(
   parameter int PEERS       = 16,
   parameter int QUEUE_DEPTH = 64,
   parameter int PREDICT_MAX = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int PIW  = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int QAW  = $clog2(QUEUE_DEPTH);
   localparam int FW   = $clog2(QUEUE_DEPTH + 1);
   localparam int UIW  = (PREDICT_MAX > 1) ? $clog2(PREDICT_MAX) : 1;
   localparam int SMX1 = (PEERS > QUEUE_DEPTH) ? PEERS : QUEUE_DEPTH;
   localparam int SMAX = (SMX1 > PREDICT_MAX) ? SMX1 : PREDICT_MAX;
   localparam int SIW  = $clog2(SMAX + 1);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_PSCAN    = 14'b00000000000010,
      S_INS_RD   = 14'b00000000000100,
      S_INS_CHK  = 14'b00000000001000,
      S_INS_WR   = 14'b00000000010000,
      S_DSCAN    = 14'b00000000100000,
      S_SEL_SCAN = 14'b00000001000000,
      S_SIM_SCAN = 14'b00000010000000,
      S_TAG_SCAN = 14'b00000100000000,
      S_SHIFT_RD = 14'b00001000000000,
      S_SHIFT_WR = 14'b00010000000000,
      S_PEER_RD  = 14'b00100000000000,
      S_PEER_WR  = 14'b01000000000000,
      S_RESP     = 14'b10000000000000
   } state_type;

   // configuration
   logic [4:0]  pcnt_ff, dcnt_ff;
   logic [15:0] pcap_ff, dcap_ff, thr_ff;
   logic [5:0]  plim_ff;

   // control
   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [FW-1:0]         pos_ff, pos_in;
   logic [SIW-1:0]        scan_idx_ff, scan_idx_in;
   logic                  eval_vld_ff, eval_vld_in;
   logic [SIW-1:0]        eval_idx_ff;
   logic [PIW-1:0]        chosen_ff, chosen_in;
   logic [1:0]            status_ff, status_in;
   logic                  have_ff, have_in;
   logic [SIM_LOAD_W-1:0] bl_ff, bl_in;
   logic [PIW-1:0]        bli_ff, bli_in;
   logic [SIM_REQ_W-1:0]  bl_req_ff, bl_req_in;
   logic [SIM_REQ_W-1:0]  br_ff, br_in;
   logic [PIW-1:0]        bri_ff, bri_in;
   logic [SIM_LOAD_W-1:0] br_load_ff, br_load_in;
   logic [15:0]           dmax_ff, dmax_in;
   logic [PREDICT_MAX-1:0] used_ff, used_in;
   logic                  sel_have_ff, sel_have_in;
   logic [23:0]           sel_best_ff, sel_best_in;
   logic [UIW-1:0]        sel_idx_ff, sel_idx_in;
   logic [23:0]           cur_len_ff, cur_len_in;
   logic                  last_ff, last_in;
   logic [PEERS-1:0]      sim_vld_ff, sim_vld_in;
   logic [PEERS-1:0]      pvalid_ff, pvalid_in;
   logic [SIW-1:0]        cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // memories
   logic            q_we, p_we, s_we;
   logic [QAW-1:0]  q_waddr, q_raddr;
   logic [PIW-1:0]  p_waddr, p_raddr, s_waddr, s_raddr;
   queue_entry_type q_wdata, q_rdata;
   peer_entry_type  p_wdata, p_rdata;
   sim_entry_type   s_wdata, s_rdata;

   // derived
   logic [7:0]     np8, dn8, lim8, t8;
   logic [15:0]    cnt16;
   logic [SIW-1:0] scan_lim;
   logic           issue, last_eval;
   logic [PIW-1:0] eidx_p;
   logic [UIW-1:0] eidx_u;
   peer_entry_type pe_scan, pe_rmw, pe_nxt;
   sim_entry_type  se;
   upd_cmd_type    ucmd;
   logic           csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      t8 = {3'b000, pcnt_ff};
      np8 = (t8 == 8'd0) ? 8'd1 : ((t8 > 8'(PEERS)) ? 8'(PEERS) : t8);
      t8 = {3'b000, dcnt_ff};
      dn8 = (t8 == 8'd0) ? 8'd1 : ((t8 > 8'(PEERS)) ? 8'(PEERS) : t8);
   end

   assign lim8  = ({2'b00, plim_ff} > 8'(PREDICT_MAX)) ? 8'(PREDICT_MAX) : {2'b00, plim_ff};
   assign cnt16 = (16'(fill_ff) < 16'(lim8)) ? 16'(fill_ff) : 16'(lim8);

   assign eidx_p  = eval_idx_ff[PIW-1:0];
   assign eidx_u  = eval_idx_ff[UIW-1:0];
   assign pe_scan = pvalid_ff[eidx_p] ? p_rdata : '0;
   assign pe_rmw  = pvalid_ff[chosen_ff] ? p_rdata : '0;
   assign se      = sim_vld_ff[eidx_p] ? s_rdata
                    : '{load: SIM_LOAD_W'({pe_scan.dtok, 2'b00}),
                        req: SIM_REQ_W'(pe_scan.dact)};

   assign ucmd = '{op: item_ff.op, length: item_ff.byte_len,
                   delta: item_ff.token_delta};

   pdld_peer_upd u_upd (
      .cmd (ucmd),
      .cur (pe_rmw),
      .nxt (pe_nxt)
   );

   always_comb begin
      unique case (state_ff)
         S_PSCAN:                scan_lim = SIW'(np8);
         S_DSCAN, S_SIM_SCAN:    scan_lim = SIW'(dn8);
         S_SEL_SCAN:             scan_lim = cnt_ff;
         S_TAG_SCAN:             scan_lim = SIW'(fill_ff);
         default:                scan_lim = '0;
      endcase
   end

   assign issue     = (scan_lim != '0) && (scan_idx_ff < scan_lim);
   assign last_eval = eval_vld_ff && (eval_idx_ff == scan_lim - SIW'(1));

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      chosen_in    = chosen_ff;
      status_in    = status_ff;
      have_in      = have_ff;
      bl_in        = bl_ff;
      bli_in       = bli_ff;
      bl_req_in    = bl_req_ff;
      br_in        = br_ff;
      bri_in       = bri_ff;
      br_load_in   = br_load_ff;
      dmax_in      = dmax_ff;
      used_in      = used_ff;
      sel_have_in  = sel_have_ff;
      sel_best_in  = sel_best_ff;
      sel_idx_in   = sel_idx_ff;
      cur_len_in   = cur_len_ff;
      last_in      = last_ff;
      sim_vld_in   = sim_vld_ff;
      pvalid_in    = pvalid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_we    = 1'b0;
      q_waddr = pos_ff[QAW-1:0];
      q_wdata = q_rdata;
      q_raddr = scan_idx_ff[QAW-1:0];
      p_we    = 1'b0;
      p_waddr = chosen_ff;
      p_wdata = pe_nxt;
      p_raddr = scan_idx_ff[PIW-1:0];
      s_we    = 1'b0;
      s_waddr = chosen_ff;
      s_wdata = se;
      s_raddr = scan_idx_ff[PIW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               status_in = ST_OK;
               have_in   = 1'b0;
               chosen_in = PIW'(req_data.peer);
               case (req_data.op)
                  OP_PF_ASSIGN:  state_in = S_PSCAN;
                  OP_DC_ASSIGN:  state_in = S_DSCAN;
                  OP_PF_RELEASE: state_in = S_TAG_SCAN;
                  OP_DC_RELEASE, OP_TOKEN_ADJ: begin
                     state_in = ({4'b0000, req_data.peer} < dn8) ? S_PEER_RD : S_RESP;
                  end
                  default:       state_in = S_RESP;
               endcase
            end
         end

         S_PSCAN: begin
            if (eval_vld_ff) begin
               if ((pe_scan.pact < pcap_ff) &&
                   (!have_ff || SIM_LOAD_W'(pe_scan.pload) < bl_ff)) begin
                  have_in = 1'b1;
                  bl_in   = SIM_LOAD_W'(pe_scan.pload);
                  bli_in  = eidx_p;
               end
               if ((eval_idx_ff == '0) || (SIM_REQ_W'(pe_scan.pact) < br_ff)) begin
                  br_in  = SIM_REQ_W'(pe_scan.pact);
                  bri_in = eidx_p;
               end
               if (last_eval) begin
                  chosen_in = have_in ? bli_in : bri_in;
                  if (fill_ff >= FW'(QUEUE_DEPTH)) begin
                     status_in = ST_QFULL;
                     state_in  = S_RESP;
                  end else begin
                     pos_in   = fill_ff;
                     state_in = S_INS_RD;
                  end
               end
            end
         end

         S_INS_RD: begin
            q_raddr = pos_ff[QAW-1:0] - QAW'(1);
            state_in = (pos_ff == '0) ? S_INS_WR : S_INS_CHK;
         end

         S_INS_CHK: begin
            if (q_rdata.time_ms > item_ff.now_ms) begin
               q_we     = 1'b1;
               pos_in   = pos_ff - FW'(1);
               state_in = S_INS_RD;
            end else begin
               state_in = S_INS_WR;
            end
         end

         S_INS_WR: begin
            q_we     = 1'b1;
            q_wdata  = '{tag: item_ff.tag, length: item_ff.byte_len,
                         time_ms: item_ff.now_ms};
            fill_in  = fill_ff + FW'(1);
            state_in = S_PEER_RD;
         end

         S_DSCAN: begin
            if (eval_vld_ff) begin
               if ((eval_idx_ff == '0) || (SIM_REQ_W'(pe_scan.dact) < br_ff)) begin
                  br_in  = SIM_REQ_W'(pe_scan.dact);
                  bri_in = eidx_p;
               end
               if ((eval_idx_ff == '0) || (pe_scan.dact > dmax_ff)) begin
                  dmax_in = pe_scan.dact;
               end
               if (last_eval) begin
                  if ((br_in[15:0] < dcap_ff) && ((dmax_in - br_in[15:0]) <= thr_ff)) begin
                     cnt_in      = SIW'(cnt16);
                     used_in     = '0;
                     sim_vld_in  = '0;
                     sel_have_in = 1'b0;
                     state_in    = S_SEL_SCAN;
                  end else begin
                     chosen_in = bri_in;
                     state_in  = S_PEER_RD;
                  end
               end
            end
         end

         S_SEL_SCAN: begin
            if (eval_vld_ff) begin
               if (!used_ff[eidx_u] && (q_rdata.length > item_ff.byte_len) &&
                   (!sel_have_ff || (q_rdata.length > sel_best_ff))) begin
                  sel_have_in = 1'b1;
                  sel_best_in = q_rdata.length;
                  sel_idx_in  = eidx_u;
               end
            end
            if ((cnt_ff == '0) || last_eval) begin
               if (sel_have_in) begin
                  cur_len_in          = sel_best_in;
                  used_in[sel_idx_in] = 1'b1;
                  last_in             = 1'b0;
               end else begin
                  cur_len_in = item_ff.byte_len;
                  last_in    = 1'b1;
               end
               have_in  = 1'b0;
               state_in = S_SIM_SCAN;
            end
         end

         S_SIM_SCAN: begin
            if (eval_vld_ff) begin
               if ((pe_scan.dact < dcap_ff) && (!have_ff || (se.load < bl_ff))) begin
                  have_in   = 1'b1;
                  bl_in     = se.load;
                  bli_in    = eidx_p;
                  bl_req_in = se.req;
               end
               if ((eval_idx_ff == '0) || (se.req < br_ff)) begin
                  br_in      = se.req;
                  bri_in     = eidx_p;
                  br_load_in = se.load;
               end
               if (last_eval) begin
                  chosen_in    = have_in ? bli_in : bri_in;
                  s_we         = 1'b1;
                  s_waddr      = chosen_in;
                  s_wdata.load = (have_in ? bl_in : br_load_in) + SIM_LOAD_W'(cur_len_ff);
                  s_wdata.req  = (have_in ? bl_req_in : br_in) + SIM_REQ_W'(1);
                  sim_vld_in[chosen_in] = 1'b1;
                  sel_have_in  = 1'b0;
                  state_in     = last_ff ? S_PEER_RD : S_SEL_SCAN;
               end
            end
         end

         S_TAG_SCAN: begin
            if (eval_vld_ff && (q_rdata.tag == item_ff.tag)) begin
               pos_in   = FW'(eval_idx_ff);
               state_in = S_SHIFT_RD;
            end else if ((fill_ff == '0) || last_eval) begin
               status_in = ST_NOT_FOUND;
               state_in  = ({4'b0000, item_ff.peer} < np8) ? S_PEER_RD : S_RESP;
            end
         end

         S_SHIFT_RD: begin
            q_raddr = pos_ff[QAW-1:0] + QAW'(1);
            if ((pos_ff + FW'(1)) < fill_ff) begin
               state_in = S_SHIFT_WR;
            end else begin
               fill_in  = fill_ff - FW'(1);
               state_in = ({4'b0000, item_ff.peer} < np8) ? S_PEER_RD : S_RESP;
            end
         end

         S_SHIFT_WR: begin
            q_we     = 1'b1;
            pos_in   = pos_ff + FW'(1);
            state_in = S_SHIFT_RD;
         end

         S_PEER_RD: begin
            p_raddr  = chosen_ff;
            state_in = S_PEER_WR;
         end

         S_PEER_WR: begin
            p_we                 = 1'b1;
            pvalid_in[chosen_ff] = 1'b1;
            state_in             = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.queued_count = 7'(fill_ff);
               rsp_data_in.chosen_peer  =
                  ((item_ff.op == OP_PF_ASSIGN) || (item_ff.op == OP_DC_ASSIGN)) ?
                  4'(chosen_ff) : item_ff.peer;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_in != state_ff) begin
         scan_idx_in = '0;
         eval_vld_in = 1'b0;
      end else begin
         scan_idx_in = issue ? scan_idx_ff + SIW'(1) : scan_idx_ff;
         eval_vld_in = issue;
      end
   end

   pdld_ram #(.WIDTH($bits(queue_entry_type)), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   pdld_ram #(.WIDTH($bits(peer_entry_type)), .DEPTH(PEERS)) u_peer_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   pdld_ram #(.WIDTH($bits(sim_entry_type)), .DEPTH(PEERS)) u_sim_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pvalid_ff    <= '0;
         scan_idx_ff  <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pcnt_ff      <= 5'd1;
         dcnt_ff      <= 5'd1;
         pcap_ff      <= 16'd16;
         dcap_ff      <= 16'd32;
         thr_ff       <= 16'd1;
         plim_ff      <= 6'd4;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pvalid_ff    <= pvalid_in;
         scan_idx_ff  <= scan_idx_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            case (csr_index)
               CSR_PF_COUNT:  pcnt_ff <= csr_data[4:0];
               CSR_DC_COUNT:  dcnt_ff <= csr_data[4:0];
               CSR_PF_CAP:    pcap_ff <= csr_data;
               CSR_DC_CAP:    dcap_ff <= csr_data;
               CSR_THRESHOLD: thr_ff  <= csr_data;
               CSR_PREDICT:   plim_ff <= csr_data[5:0];
               default:       ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      eval_idx_ff <= scan_idx_ff;
      chosen_ff   <= chosen_in;
      status_ff   <= status_in;
      have_ff     <= have_in;
      bl_ff       <= bl_in;
      bli_ff      <= bli_in;
      bl_req_ff   <= bl_req_in;
      br_ff       <= br_in;
      bri_ff      <= bri_in;
      br_load_ff  <= br_load_in;
      dmax_ff     <= dmax_in;
      used_ff     <= used_in;
      sel_have_ff <= sel_have_in;
      sel_best_ff <= sel_best_in;
      sel_idx_ff  <= sel_idx_in;
      cur_len_ff  <= cur_len_in;
      last_ff     <= last_in;
      sim_vld_ff  <= sim_vld_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item left no work");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_RESP))
      else $error("result raised outside response state");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(fill_ff))
      else $error("queue fill changed while idle");
`endif

endmodule

`default_nettype wire
